### src/etfp_pkg.sv
// Package for the escape-time fractal pixel unit: shared types, register
// indexes, controller states, reset values and saturation helper.
// No dependencies.
package etfp_pkg;

   localparam int COORD_W      = 32;
   localparam int FRAC_BITS    = 28;
   localparam int CAP_W        = 13;
   localparam int INDEX_W      = 10;
   localparam int REG_INDEX_W  = 3;
   localparam int SUM_W        = 48;
   localparam int ALPHA_W      = 8;
   localparam int DIV_STEP_W   = 3;
   localparam int DIV_REM_W    = CAP_W + ALPHA_W;

   localparam int DEFAULT_IMAGE_WIDTH  = 1024;
   localparam int DEFAULT_IMAGE_HEIGHT = 1024;

   localparam logic [REG_INDEX_W-1:0] REG_FRACTAL_MODE  = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_JULIA_C_REAL  = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_JULIA_C_IMAG  = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_ITERATION_CAP = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_WINDOW_LEFT   = 3'd4;
   localparam logic [REG_INDEX_W-1:0] REG_WINDOW_RIGHT  = 3'd5;
   localparam logic [REG_INDEX_W-1:0] REG_WINDOW_TOP    = 3'd6;
   localparam logic [REG_INDEX_W-1:0] REG_WINDOW_BOTTOM = 3'd7;

   localparam logic                       RST_FRACTAL_MODE  = 1'b1;
   localparam logic signed [COORD_W-1:0]  RST_JULIA_C_REAL  = 32'sd40265318;
   localparam logic signed [COORD_W-1:0]  RST_JULIA_C_IMAG  = 32'sd170456515;
   localparam logic [CAP_W-1:0]           RST_ITERATION_CAP = 13'd64;
   localparam logic signed [COORD_W-1:0]  RST_WINDOW_LEFT   = -32'sd536870912;
   localparam logic signed [COORD_W-1:0]  RST_WINDOW_RIGHT  = 32'sd536870912;
   localparam logic signed [COORD_W-1:0]  RST_WINDOW_TOP    = -32'sd536870912;
   localparam logic signed [COORD_W-1:0]  RST_WINDOW_BOTTOM = 32'sd536870912;

   // |z|^2 bound of 4.0 in the Q8.56 scale of the squared terms.
   localparam logic [63:0] ESCAPE_SQ = 64'd4 << (2 * FRAC_BITS);

   localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [23:0]        RGB_WHITE    = 24'hFFFFFF;
   localparam logic [23:0]        RGB_BLACK    = 24'h000000;

   typedef struct packed {
      logic                      fractal_mode;
      logic signed [COORD_W-1:0] julia_c_real;
      logic signed [COORD_W-1:0] julia_c_imag;
      logic [CAP_W-1:0]          iteration_cap;
      logic signed [COORD_W-1:0] window_left;
      logic signed [COORD_W-1:0] window_right;
      logic signed [COORD_W-1:0] window_top;
      logic signed [COORD_W-1:0] window_bottom;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAPX_MUL,
      ST_MAPX_ADD,
      ST_MAPY_MUL,
      ST_MAPY_ADD,
      ST_INIT,
      ST_MUL,
      ST_UPD,
      ST_DIV_INIT,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_idx;
      logic map_mul;
      logic map_add;
      logic axis_y;
      logic init_iter;
      logic iter_mul;
      logic iter_upd;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic at_cap;
      logic escaped;
      logic div_last;
      logic out_free;
   } status_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi_lim;
      logic signed [SUM_W-1:0] lo_lim;
      hi_lim = SUM_W'(32'sh7FFFFFFF);
      lo_lim = -hi_lim - SUM_W'(1);
      if (v > hi_lim) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo_lim) begin
         return 32'sh80000000;
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

### src/etfp_req_if.sv
// Request channel interface: pixel column and row with valid/ready.
// Depends on etfp_pkg.
interface etfp_req_if;
   logic                             valid;
   logic                             ready;
   logic [etfp_pkg::INDEX_W-1:0]     pixel_column;
   logic [etfp_pkg::INDEX_W-1:0]     pixel_row;

   modport source (output valid, output pixel_column, output pixel_row, input ready);
   modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

### src/etfp_rsp_if.sv
// Response channel interface: RGBA colour and escape count with valid/ready.
// Depends on etfp_pkg.
interface etfp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [31:0]                    pixel_colour;
   logic [etfp_pkg::CAP_W-1:0]     escape_count;

   modport source (output valid, output pixel_colour, output escape_count, input ready);
   modport sink   (input valid, input pixel_colour, input escape_count, output ready);
endinterface

### src/etfp_regs.sv
// Configuration register file written through the plain CSR write port.
// Depends on etfp_pkg.
module etfp_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [etfp_pkg::REG_INDEX_W-1:0]    csr_index,
   input  logic [etfp_pkg::COORD_W-1:0]        csr_write_data,
   output etfp_pkg::cfg_type                   cfg
);

   etfp_pkg::cfg_type cfg_ff;
   etfp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            etfp_pkg::REG_FRACTAL_MODE:  cfg_in.fractal_mode  = csr_write_data[0];
            etfp_pkg::REG_JULIA_C_REAL:  cfg_in.julia_c_real  = csr_write_data;
            etfp_pkg::REG_JULIA_C_IMAG:  cfg_in.julia_c_imag  = csr_write_data;
            etfp_pkg::REG_ITERATION_CAP:
               cfg_in.iteration_cap = csr_write_data[etfp_pkg::CAP_W-1:0];
            etfp_pkg::REG_WINDOW_LEFT:   cfg_in.window_left   = csr_write_data;
            etfp_pkg::REG_WINDOW_RIGHT:  cfg_in.window_right  = csr_write_data;
            etfp_pkg::REG_WINDOW_TOP:    cfg_in.window_top    = csr_write_data;
            etfp_pkg::REG_WINDOW_BOTTOM: cfg_in.window_bottom = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fractal_mode  <= etfp_pkg::RST_FRACTAL_MODE;
         cfg_ff.julia_c_real  <= etfp_pkg::RST_JULIA_C_REAL;
         cfg_ff.julia_c_imag  <= etfp_pkg::RST_JULIA_C_IMAG;
         cfg_ff.iteration_cap <= etfp_pkg::RST_ITERATION_CAP;
         cfg_ff.window_left   <= etfp_pkg::RST_WINDOW_LEFT;
         cfg_ff.window_right  <= etfp_pkg::RST_WINDOW_RIGHT;
         cfg_ff.window_top    <= etfp_pkg::RST_WINDOW_TOP;
         cfg_ff.window_bottom <= etfp_pkg::RST_WINDOW_BOTTOM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/etfp_ctrl.sv
// Controller state machine: sequences mapping, iteration, alpha division
// and result hand-off. Depends on etfp_pkg.
module etfp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  etfp_pkg::status_type   status,
   output etfp_pkg::cmd_type      cmd
);

   etfp_pkg::state_type state_ff;
   etfp_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         etfp_pkg::ST_IDLE:     if (req_valid) state_in = etfp_pkg::ST_MAPX_MUL;
         etfp_pkg::ST_MAPX_MUL: state_in = etfp_pkg::ST_MAPX_ADD;
         etfp_pkg::ST_MAPX_ADD: state_in = etfp_pkg::ST_MAPY_MUL;
         etfp_pkg::ST_MAPY_MUL: state_in = etfp_pkg::ST_MAPY_ADD;
         etfp_pkg::ST_MAPY_ADD: state_in = etfp_pkg::ST_INIT;
         etfp_pkg::ST_INIT:     state_in = etfp_pkg::ST_MUL;
         etfp_pkg::ST_MUL:      state_in = etfp_pkg::ST_UPD;
         etfp_pkg::ST_UPD: begin
            if (status.at_cap) begin
               state_in = etfp_pkg::ST_OUT;
            end else if (status.escaped) begin
               state_in = etfp_pkg::ST_DIV_INIT;
            end else begin
               state_in = etfp_pkg::ST_MUL;
            end
         end
         etfp_pkg::ST_DIV_INIT: state_in = etfp_pkg::ST_DIV;
         etfp_pkg::ST_DIV:      if (status.div_last) state_in = etfp_pkg::ST_OUT;
         etfp_pkg::ST_OUT:      if (status.out_free) state_in = etfp_pkg::ST_IDLE;
         default:               state_in = etfp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         etfp_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_idx = req_valid;
         end
         etfp_pkg::ST_MAPX_MUL: cmd.map_mul = 1'b1;
         etfp_pkg::ST_MAPX_ADD: cmd.map_add = 1'b1;
         etfp_pkg::ST_MAPY_MUL: begin
            cmd.map_mul = 1'b1;
            cmd.axis_y  = 1'b1;
         end
         etfp_pkg::ST_MAPY_ADD: begin
            cmd.map_add = 1'b1;
            cmd.axis_y  = 1'b1;
         end
         etfp_pkg::ST_INIT:     cmd.init_iter = 1'b1;
         etfp_pkg::ST_MUL:      cmd.iter_mul  = 1'b1;
         etfp_pkg::ST_UPD:      cmd.iter_upd  = !status.at_cap && !status.escaped;
         etfp_pkg::ST_DIV_INIT: cmd.div_start = 1'b1;
         etfp_pkg::ST_DIV:      cmd.div_step  = 1'b1;
         etfp_pkg::ST_OUT:      cmd.out_load  = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= etfp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/etfp_dp.sv
// Datapath: window mapping, complex squaring with saturation, restoring
// alpha divider and the result register. Depends on etfp_pkg.
module etfp_dp #(
   parameter int COL_SHIFT = 10,
   parameter int ROW_SHIFT = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  etfp_pkg::cfg_type                   cfg,
   input  etfp_pkg::cmd_type                   cmd,
   output etfp_pkg::status_type                status,
   input  logic [etfp_pkg::INDEX_W-1:0]        pixel_column,
   input  logic [etfp_pkg::INDEX_W-1:0]        pixel_row,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [31:0]                         pixel_colour,
   output logic [etfp_pkg::CAP_W-1:0]          escape_count
);

   localparam int CW    = etfp_pkg::COORD_W;
   localparam int PROD_W = CW + 1 + etfp_pkg::INDEX_W + 1;

   logic [etfp_pkg::INDEX_W-1:0]       col_ff, row_ff;
   logic signed [PROD_W-1:0]           map_prod_ff;
   logic signed [CW-1:0]               x_ff, y_ff, cr_ff, ci_ff;
   logic signed [63:0]                 xx_ff, yy_ff, xy_ff;
   logic [etfp_pkg::CAP_W-1:0]         count_ff;
   logic [etfp_pkg::DIV_REM_W-1:0]     rem_ff;
   logic [etfp_pkg::ALPHA_W-1:0]       quot_ff;
   logic [etfp_pkg::DIV_STEP_W-1:0]    step_ff;
   logic                               out_valid_ff;
   logic [31:0]                        colour_ff;
   logic [etfp_pkg::CAP_W-1:0]         count_out_ff;

   logic signed [CW:0]                 map_diff;
   logic signed [etfp_pkg::INDEX_W:0]  map_idx;
   logic signed [PROD_W-1:0]           map_prod_in;
   logic signed [PROD_W-1:0]           map_shifted;
   logic signed [CW-1:0]               map_lo;
   logic signed [CW-1:0]               map_result;
   logic signed [63:0]                 re_diff, re_shift, im_shift;
   logic signed [CW-1:0]               x_in, y_in;
   logic [63:0]                        mag_sq;
   logic [etfp_pkg::DIV_REM_W-1:0]     div_sub;
   logic [etfp_pkg::DIV_REM_W:0]       div_trial;

   // Linear map: lo + floor((hi - lo) * index / 2^shift), saturated.
   always_comb begin
      if (cmd.axis_y) begin
         map_lo   = cfg.window_top;
         map_diff = {cfg.window_bottom[CW-1], cfg.window_bottom}
                    - {cfg.window_top[CW-1], cfg.window_top};
         map_idx  = $signed({1'b0, row_ff});
      end else begin
         map_lo   = cfg.window_left;
         map_diff = {cfg.window_right[CW-1], cfg.window_right}
                    - {cfg.window_left[CW-1], cfg.window_left};
         map_idx  = $signed({1'b0, col_ff});
      end
      map_prod_in = map_diff * map_idx;
      map_shifted = cmd.axis_y ? (map_prod_ff >>> ROW_SHIFT) : (map_prod_ff >>> COL_SHIFT);
      map_result  = etfp_pkg::sat32(etfp_pkg::SUM_W'(map_lo)
                                    + etfp_pkg::SUM_W'(map_shifted));
   end

   // One iteration: squares are registered, then tested and folded back.
   always_comb begin
      mag_sq   = 64'(xx_ff) + 64'(yy_ff);
      re_diff  = xx_ff - yy_ff;
      re_shift = re_diff >>> etfp_pkg::FRAC_BITS;
      im_shift = xy_ff >>> (etfp_pkg::FRAC_BITS - 1);
      x_in     = etfp_pkg::sat32(etfp_pkg::SUM_W'(re_shift[etfp_pkg::SUM_W-1:0])
                                 + etfp_pkg::SUM_W'(cr_ff));
      y_in     = etfp_pkg::sat32(etfp_pkg::SUM_W'(im_shift[etfp_pkg::SUM_W-1:0])
                                 + etfp_pkg::SUM_W'(ci_ff));
   end

   always_comb begin
      div_sub   = etfp_pkg::DIV_REM_W'({{etfp_pkg::ALPHA_W{1'b0}}, cfg.iteration_cap}
                                       << step_ff);
      div_trial = {1'b0, rem_ff} - {1'b0, div_sub};
   end

   assign status.at_cap   = (count_ff == cfg.iteration_cap);
   assign status.escaped  = (mag_sq > etfp_pkg::ESCAPE_SQ);
   assign status.div_last = (step_ff == '0);
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load_idx) begin
         col_ff <= pixel_column;
         row_ff <= pixel_row;
      end
      if (cmd.map_mul) begin
         map_prod_ff <= map_prod_in;
      end
      if (cmd.map_add) begin
         if (cmd.axis_y) begin
            y_ff <= map_result;
         end else begin
            x_ff <= map_result;
         end
      end
      if (cmd.init_iter) begin
         cr_ff    <= cfg.fractal_mode ? cfg.julia_c_real : x_ff;
         ci_ff    <= cfg.fractal_mode ? cfg.julia_c_imag : y_ff;
         count_ff <= '0;
      end
      if (cmd.iter_mul) begin
         xx_ff <= x_ff * x_ff;
         yy_ff <= y_ff * y_ff;
         xy_ff <= x_ff * y_ff;
      end
      if (cmd.iter_upd) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         count_ff <= count_ff + 1'b1;
      end
      if (cmd.div_start) begin
         // 255 * count as (count << 8) - count.
         rem_ff  <= {count_ff, {etfp_pkg::ALPHA_W{1'b0}}} - etfp_pkg::DIV_REM_W'(count_ff);
         quot_ff <= '0;
         step_ff <= etfp_pkg::DIV_STEP_W'(etfp_pkg::ALPHA_W - 1);
      end
      if (cmd.div_step) begin
         if (!div_trial[etfp_pkg::DIV_REM_W]) begin
            rem_ff           <= div_trial[etfp_pkg::DIV_REM_W-1:0];
            quot_ff[step_ff] <= 1'b1;
         end
         step_ff <= step_ff - 1'b1;
      end
      if (cmd.out_load) begin
         count_out_ff <= count_ff;
         colour_ff    <= status.at_cap ? {etfp_pkg::RGB_BLACK, etfp_pkg::ALPHA_OPAQUE}
                                       : {etfp_pkg::RGB_WHITE, quot_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign pixel_colour = colour_ff;
   assign escape_count = count_out_ff;

endmodule

### src/escape_time_fractal_pixel_top.sv
// Top level of the escape-time fractal pixel unit (Mandelbrot / Julia).
// Depends on etfp_pkg, etfp_req_if, etfp_rsp_if, etfp_regs, etfp_ctrl, etfp_dp.
//
// Usage: a request transaction on req_chan carries a pixel column and row.
// The point is mapped into the configured window, iterated as z = z^2 + c,
// and one response transaction on rsp_chan returns the escape count and an
// RGBA colour. Registers are written through csr_write_enable, csr_index
// and csr_write_data, only while the unit is idle; the user is bound to
// this, and the block itself does not enforce it.
// Steps: mapping and setup (ST_MAPX_MUL, ST_MAPX_ADD, ST_MAPY_MUL,
// ST_MAPY_ADD, ST_INIT), then per iteration one state for the three 32x32
// products and one for the escape test and update, plus one more pair for
// the test that ends the loop, then restoring division for alpha unless
// the cap was reached, then the load into the result register. A new pixel
// is taken only once the last one has been loaded into the result register.
// One pixel is in work at a time; req_chan.ready is high only while idle.
// A finished result waits in the result register while the next request is
// accepted; if the receiver stalls with both full, the unit holds before
// loading its next result.
// Reset (synchronous, active high) restores the register defaults and
// empties the result register.
module escape_time_fractal_pixel_top #(
   parameter int IMAGE_WIDTH  = etfp_pkg::DEFAULT_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = etfp_pkg::DEFAULT_IMAGE_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   etfp_req_if.sink                          req_chan,
   etfp_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [etfp_pkg::REG_INDEX_W-1:0]  csr_index,
   input  logic [etfp_pkg::COORD_W-1:0]      csr_write_data
);

   localparam int COL_SHIFT = $clog2(IMAGE_WIDTH);
   localparam int ROW_SHIFT = $clog2(IMAGE_HEIGHT);

   etfp_pkg::cfg_type    cfg;
   etfp_pkg::cmd_type    cmd;
   etfp_pkg::status_type status;

   etfp_regs u_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   etfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   etfp_dp #(
      .COL_SHIFT (COL_SHIFT),
      .ROW_SHIFT (ROW_SHIFT)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .status       (status),
      .pixel_column (req_chan.pixel_column),
      .pixel_row    (req_chan.pixel_row),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .pixel_colour (rsp_chan.pixel_colour),
      .escape_count (rsp_chan.escape_count)
   );

   // Only one pixel is in work: the cycle after a request, the unit is busy.
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted while a pixel was in work");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.escape_count <= cfg.iteration_cap)
      else $error("escape count above the iteration cap");

   a_colour_form: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.escape_count != cfg.iteration_cap
      |-> rsp_chan.pixel_colour[31:8] == etfp_pkg::RGB_WHITE)
      else $error("escaped pixel without white colour");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_chan.valid || rsp_chan.ready)
      else $error("result register overwritten before it was taken");

endmodule
